@@ design/lsra_pkg.sv @@
// Shared constants, field types and helpers for the log segment ring allocator.
package lsra_pkg;

	// Ring geometry
	localparam int RING_DEPTH = 64;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int LIVE_W     = $clog2(RING_DEPTH + 1);

	// Field widths
	localparam int FUNC_W     = 2;
	localparam int LEN_W      = 25;
	localparam int ID_W       = 16;   // ids wrap at 2**ID_W, i.e. after the largest id 65535
	localparam int TIME_W     = 32;
	localparam int STAT_W     = 2;
	localparam int OFF_W      = 25;
	localparam int CNT_W      = 6;
	localparam int MAXC_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Stream word layout
	localparam int S_LEN_LO   = 0;
	localparam int S_ID_LO    = S_LEN_LO + LEN_W;
	localparam int S_NOW_LO   = S_ID_LO + ID_W;
	localparam int S_FIELDS_W = S_NOW_LO + TIME_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

	localparam int M_FIELDS_W = STAT_W + ID_W + OFF_W + TIME_W + CNT_W + 1 + ID_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

	// Byte limits
	localparam logic [LEN_W-1:0] MAX_VALUE_BYTES = LEN_W'(1048576);
	localparam logic [LEN_W:0]   SEGMENT_BYTES   = (LEN_W + 1)'(16777216);
	localparam logic [OFF_W-1:0] HEADER_BYTES    = OFF_W'(64);

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TTL       = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [LEN_W-1:0]  length;
		logic [ID_W-1:0]   segment_id;
		logic [TIME_W-1:0] clock_secs;
	} cmd_t;

	typedef struct packed {
		logic [MAXC_W-1:0] max_count;
		logic [TIME_W-1:0] ttl;
	} cfg_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   result_segment;
		logic [OFF_W-1:0]  result_offset;
		logic [TIME_W-1:0] create_secs;
		logic [CNT_W-1:0]  removed_count;
		logic              evicted;
		logic [ID_W-1:0]   evicted_segment;
	} res_t;

	// Wrap a slot sum that is known to stay below twice the ring depth.
	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [LIVE_W:0] sum);
		logic [LIVE_W:0] adj;
		adj = (sum >= (LIVE_W + 1)'(RING_DEPTH)) ? sum - (LIVE_W + 1)'(RING_DEPTH) : sum;
		return adj[SLOT_W-1:0];
	endfunction

endpackage

@@ design/lsra_core.sv @@
// Sequencer and creation-time memory of the segment ring.
module lsra_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lsra_pkg::cmd_t    cmd,
	input  lsra_pkg::cfg_t    cfg,
	output logic              res_valid,
	input  logic              res_ready,
	output lsra_pkg::res_t    res
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_LOOK    = 3'd2;
	localparam logic [2:0] S_EXP_RD  = 3'd3;
	localparam logic [2:0] S_EXP_CHK = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]                        state_q;
	lsra_pkg::cmd_t                    cmd_q;
	lsra_pkg::res_t                    res_q;
	logic                              found_q;
	logic [lsra_pkg::SLOT_W-1:0]       head_slot_q;
	logic [lsra_pkg::LIVE_W-1:0]       live_q;
	logic [lsra_pkg::ID_W-1:0]         head_id_q;
	logic [lsra_pkg::OFF_W-1:0]        tail_q;

	logic [lsra_pkg::TIME_W-1:0]       create_times_q [lsra_pkg::RING_DEPTH];
	logic [lsra_pkg::TIME_W-1:0]       rd_data_q;

	logic                              rd_en;
	logic [lsra_pkg::SLOT_W-1:0]       rd_addr;
	logic                              wr_en;

	logic [lsra_pkg::ID_W-1:0]         live_ext;
	logic                              too_large;
	logic [lsra_pkg::LEN_W:0]          fit_sum;
	logic                              empty;
	logic                              open_new;
	logic                              full;
	logic [lsra_pkg::LIVE_W-1:0]       live_inc;
	logic                              over_max;
	logic                              evict;
	logic [lsra_pkg::ID_W-1:0]         base_id;
	logic [lsra_pkg::ID_W-1:0]         new_id;
	logic [lsra_pkg::ID_W-1:0]         tail_id;
	logic [lsra_pkg::SLOT_W-1:0]       wr_slot;
	logic [lsra_pkg::SLOT_W-1:0]       next_slot;
	logic [lsra_pkg::ID_W-1:0]         look_pos;
	logic                              look_found;
	logic [lsra_pkg::SLOT_W-1:0]       look_slot;
	logic [lsra_pkg::TIME_W-1:0]       age;
	logic                              expire_hit;
	lsra_pkg::res_t                    res_exec;

	always_comb begin
		live_ext   = lsra_pkg::ID_W'(live_q);
		too_large  = (cmd_q.func == lsra_pkg::FUNC_APPEND || cmd_q.func == lsra_pkg::FUNC_LOOKUP)
			&& (cmd_q.length > lsra_pkg::MAX_VALUE_BYTES);
		fit_sum    = (lsra_pkg::LEN_W + 1)'(cmd_q.length) + (lsra_pkg::LEN_W + 1)'(tail_q);
		empty      = (live_q == '0);
		open_new   = empty || (fit_sum > lsra_pkg::SEGMENT_BYTES);
		full       = (live_q >= lsra_pkg::LIVE_W'(lsra_pkg::RING_DEPTH));
		live_inc   = live_q + 1'b1;
		over_max   = (cfg.max_count != '0) && (32'(live_inc) > 32'(cfg.max_count));
		evict      = open_new && (full || over_max);
		base_id    = empty ? '0 : head_id_q;
		new_id     = base_id + live_ext;
		tail_id    = head_id_q + live_ext - 1'b1;
		// A full ring writes over the oldest slot, which is head + live modulo the depth.
		wr_slot    = lsra_pkg::wrap_slot((lsra_pkg::LIVE_W + 1)'(head_slot_q)
			+ (lsra_pkg::LIVE_W + 1)'(live_q));
		next_slot  = lsra_pkg::wrap_slot((lsra_pkg::LIVE_W + 1)'(head_slot_q)
			+ (lsra_pkg::LIVE_W + 1)'(1));
		look_pos   = cmd_q.segment_id - head_id_q;
		look_found = (look_pos < live_ext);
		look_slot  = lsra_pkg::wrap_slot((lsra_pkg::LIVE_W + 1)'(head_slot_q)
			+ (lsra_pkg::LIVE_W + 1)'(look_pos[lsra_pkg::SLOT_W-1:0]));
		age        = cmd_q.clock_secs - rd_data_q;
		expire_hit = (cmd_q.clock_secs > rd_data_q) && (age >= cfg.ttl);
	end

	always_comb begin
		res_exec = '0;
		if (too_large) begin
			res_exec.status = lsra_pkg::STAT_TOO_LARGE;
		end else if (cmd_q.func == lsra_pkg::FUNC_APPEND) begin
			res_exec.result_segment  = open_new ? new_id : tail_id;
			res_exec.result_offset   = open_new ? lsra_pkg::HEADER_BYTES : tail_q;
			res_exec.evicted         = evict;
			res_exec.evicted_segment = evict ? head_id_q : '0;
		end
	end

	// Memory port control: one read, one write, never both in the same cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_slot_q;
		if (state_q == S_EXEC && cmd_q.func == lsra_pkg::FUNC_LOOKUP) begin
			rd_en   = 1'b1;
			rd_addr = look_slot;
		end else if (state_q == S_EXP_RD) begin
			rd_en = 1'b1;
		end
		wr_en = (state_q == S_EXEC) && (cmd_q.func == lsra_pkg::FUNC_APPEND)
			&& !too_large && open_new;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			create_times_q[wr_slot] <= cmd_q.clock_secs;
		end
		if (rd_en) begin
			rd_data_q <= create_times_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_slot_q <= '0;
			live_q      <= '0;
			head_id_q   <= '0;
			tail_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (too_large) begin
						state_q <= S_DONE;
					end else begin
						case (cmd_q.func)
							lsra_pkg::FUNC_APPEND: begin
								if (open_new) begin
									head_slot_q <= evict ? next_slot : head_slot_q;
									head_id_q   <= evict ? base_id + 1'b1 : base_id;
									live_q      <= evict ? live_q : live_inc;
									tail_q      <= lsra_pkg::HEADER_BYTES + cmd_q.length;
								end else begin
									tail_q <= fit_sum[lsra_pkg::OFF_W-1:0];
								end
								state_q <= S_DONE;
							end
							lsra_pkg::FUNC_LOOKUP: begin
								state_q <= S_LOOK;
							end
							lsra_pkg::FUNC_EXPIRE: begin
								state_q <= (cfg.ttl != '0) ? S_EXP_RD : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_LOOK: begin
					state_q <= S_DONE;
				end
				S_EXP_RD: begin
					// Always keep the newest segment.
					state_q <= (live_q > lsra_pkg::LIVE_W'(1)) ? S_EXP_CHK : S_DONE;
				end
				S_EXP_CHK: begin
					if (expire_hit) begin
						head_slot_q <= next_slot;
						head_id_q   <= head_id_q + 1'b1;
						live_q      <= live_q - 1'b1;
						state_q     <= S_EXP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			S_EXEC: begin
				res_q   <= res_exec;
				found_q <= look_found;
			end
			S_LOOK: begin
				res_q.status      <= found_q ? lsra_pkg::STAT_OK : lsra_pkg::STAT_NOT_FOUND;
				res_q.create_secs <= found_q ? rd_data_q : '0;
			end
			S_EXP_CHK: begin
				// Saturate the removal count.
				if (expire_hit && res_q.removed_count != '1) begin
					res_q.removed_count <= res_q.removed_count + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

@@ design/log_segment_ring_allocator.sv @@
// Top level of the log segment ring allocator: stream ports, registers, output word.
// One item at a time: the next word is accepted only after the last result has left the core;
// an append, a rejected word or an expire with expiry off passes through execute and done, a
// lookup adds a read state, and an expire reads and checks the oldest segment in turn.
// The single-port read of the creation-time memory sets the per-step pace of expiry.
// Reset clears the ring pointers, the live count, the tail offset and both registers;
// creation-time memory contents stay undefined and are used only for live segments.
module log_segment_ring_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input words
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// length [24:0], segment_id [40:25], clock_secs [72:41], zero fill above
	input  logic [lsra_pkg::S_DATA_W-1:0]       s_tdata,
	// func [1:0]
	input  logic [lsra_pkg::FUNC_W-1:0]         s_tuser,
	// Result words
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status [1:0], result_segment [17:2], result_offset [42:18], create_secs [74:43],
	// removed_count [80:75], evicted [81], evicted_segment [97:82], zero fill above
	output logic [lsra_pkg::M_DATA_W-1:0]       m_tdata,
	// Register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsra_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsra_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lsra_pkg::cmd_t                    cmd;
	lsra_pkg::cfg_t                    cfg_q;
	lsra_pkg::res_t                    res;
	logic                              res_valid;
	logic                              res_ready;
	logic                              m_tvalid_q;
	logic [lsra_pkg::M_DATA_W-1:0]     m_tdata_q;

	// Unpack the input word.
	always_comb begin
		cmd.func       = s_tuser;
		cmd.length     = s_tdata[lsra_pkg::S_LEN_LO +: lsra_pkg::LEN_W];
		cmd.segment_id = s_tdata[lsra_pkg::S_ID_LO +: lsra_pkg::ID_W];
		cmd.clock_secs = s_tdata[lsra_pkg::S_NOW_LO +: lsra_pkg::TIME_W];
	end

	// Registers take a write at any time; the user must write only while the block is idle, unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lsra_pkg::CFG_MAX_COUNT: begin
					cfg_q.max_count <= cfg_data[lsra_pkg::MAXC_W-1:0];
				end
				lsra_pkg::CFG_TTL: begin
					cfg_q.ttl <= cfg_data[lsra_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	lsra_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the core hands over a result whenever the slot is empty or draining.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {{lsra_pkg::M_PAD_W{1'b0}}, res.evicted_segment, res.evicted,
				res.removed_count, res.create_secs, res.result_offset, res.result_segment,
				res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ verif/tb_log_segment_ring_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the log segment ring allocator: stream stimulus, model, scoreboard.
module tb_log_segment_ring_allocator;
	import lsra_pkg::*;

	// The block answers func 3 with an all-zero word; the package has no name for it.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// No handshake for this many cycles means the block has hung.
	// Worst case per word: a full expiry walk, gaps on both sides and the long receiver hold.
	localparam int WATCHDOG_LIMIT = 4000;
	// Cycles to watch for stray result words once nothing is expected.
	localparam int DRAIN_TAIL = 140;
	localparam int RING_FILL_WORDS = 200;
	localparam int RANDOM_WORDS = 200;

	// Result word layout, lowest field first
	localparam int R_STAT_LO  = 0;
	localparam int R_SEG_LO   = R_STAT_LO + STAT_W;
	localparam int R_OFS_LO   = R_SEG_LO + ID_W;
	localparam int R_SECS_LO  = R_OFS_LO + OFF_W;
	localparam int R_RM_LO    = R_SECS_LO + TIME_W;
	localparam int R_EV_BIT   = R_RM_LO + CNT_W;
	localparam int R_EVSEG_LO = R_EV_BIT + 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	log_segment_ring_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Ring model: the testbench's own copy of the segment ring and registers
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] seg_born [RING_DEPTH];   // creation stamp per slot
	logic [SLOT_W-1:0] oldest_slot = '0;
	logic [LIVE_W-1:0] seg_count = '0;
	logic [ID_W-1:0]   oldest_id = '0;
	logic [OFF_W-1:0]  fill_ofs = '0;           // first free byte of the newest segment
	logic [MAXC_W-1:0] cap_cfg = '0;
	logic [TIME_W-1:0] ttl_cfg = '0;

	res_t        expected_results [$];
	int unsigned mismatch_count = 0;

	// Idle controls shared by the tests and the result sink
	int unsigned src_gap_max = 0;
	int unsigned sink_gap_max = 0;
	int unsigned hold_req = 0;
	int unsigned wall_secs = 1000;

	// Coverage tallies for the closing summary
	int unsigned words_sent = 0;
	int unsigned appends_placed = 0;
	int unsigned lookups_found = 0;
	int unsigned segments_opened = 0;
	int unsigned depth_evictions = 0;
	int unsigned count_evictions = 0;
	int unsigned segments_expired = 0;

	// Drop the oldest segment, return its id.
	function automatic logic [ID_W-1:0] retire_oldest();
		logic [ID_W-1:0] gone;
		gone = oldest_id;
		oldest_slot = oldest_slot + 1'b1;
		oldest_id = oldest_id + 1'b1;
		seg_count = seg_count - 1'b1;
		return gone;
	endfunction

	// Advance the ring by one accepted command word and return the result word it causes.
	function automatic res_t predict_result(input cmd_t c);
		res_t              r;
		logic [ID_W-1:0]   pos;
		logic [TIME_W-1:0] born;
		logic [TIME_W-1:0] age;
		int unsigned       n;
		r = '0;
		n = 0;
		if ((c.func == FUNC_APPEND || c.func == FUNC_LOOKUP) && c.length > MAX_VALUE_BYTES) begin
			r.status = STAT_TOO_LARGE;
		end else if (c.func == FUNC_APPEND) begin
			// Open a segment when the store is empty or the word spills past the end of the segment.
			if (seg_count == 0 || {1'b0, c.length} + {1'b0, fill_ofs} > SEGMENT_BYTES) begin
				if (seg_count >= RING_DEPTH) begin
					r.evicted = 1'b1;
					r.evicted_segment = retire_oldest();
					depth_evictions++;
				end
				seg_born[SLOT_W'(oldest_slot + seg_count)] = c.clock_secs;
				seg_count = seg_count + 1'b1;
				fill_ofs = HEADER_BYTES;
				segments_opened++;
				// At most one eviction per append, even with the limit far below the count.
				if (!r.evicted && cap_cfg != 0 && seg_count > cap_cfg) begin
					r.evicted = 1'b1;
					r.evicted_segment = retire_oldest();
					count_evictions++;
				end
			end
			r.result_segment = oldest_id + ID_W'(seg_count - 1'b1);
			r.result_offset = fill_ofs;
			fill_ofs = fill_ofs + c.length;
			appends_placed++;
		end else if (c.func == FUNC_LOOKUP) begin
			pos = c.segment_id - oldest_id;
			if (pos >= seg_count) begin
				r.status = STAT_NOT_FOUND;
			end else begin
				r.create_secs = seg_born[SLOT_W'(oldest_slot + pos)];
				lookups_found++;
			end
		end else if (c.func == FUNC_EXPIRE && ttl_cfg != 0) begin
			// Walk from the oldest; stop on a young segment, a clock that is not ahead or one segment left.
			while (seg_count > 1) begin
				born = seg_born[oldest_slot];
				age = c.clock_secs - born;
				if (c.clock_secs <= born || age < ttl_cfg)
					break;
				void'(retire_oldest());
				n++;
			end
			r.removed_count = (n > 63) ? CNT_W'(63) : CNT_W'(n);
			segments_expired += n;
		end
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		if (mismatch_count < 10)
			$display("%s", msg);
		mismatch_count++;
	endfunction

	// ------------------------------------------------------------------
	// Driving helpers
	// ------------------------------------------------------------------

	// Offer one command word; return once it is accepted and its result is queued.
	task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [LEN_W-1:0] len,
			input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
		cmd_t        c;
		int unsigned gap;
		c.func = op;
		c.length = len;
		c.segment_id = id;
		c.clock_secs = now;
		gap = $urandom_range(src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// tvalid stays high across back-to-back words
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= S_DATA_W'({now, id, len});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(predict_result(c));
		words_sent++;
	endtask

	// Stop offering and hold until every queued result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Register write; call only with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAX_COUNT)
			cap_cfg = val[MAXC_W-1:0];
		else
			ttl_cfg = val;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every op and the corner cases on a nearly empty store.
	task automatic test_directed();
		src_gap_max = 0;
		sink_gap_max = 0;
		send_cmd(FUNC_LOOKUP, '0, '0, 32'd0);                      // empty store: not found
		send_cmd(FUNC_EXPIRE, '0, '0, 32'd5);
		send_cmd(FUNC_UNUSED, '1, '1, '1);                         // unused op: all-zero answer
		send_cmd(FUNC_APPEND, '0, '0, 32'd10);                     // first segment, after the header
		send_cmd(FUNC_APPEND, MAX_VALUE_BYTES, '1, '1);            // largest legal length
		send_cmd(FUNC_APPEND, MAX_VALUE_BYTES + 1'b1, '0, '0);     // one byte too many
		send_cmd(FUNC_APPEND, '1, '0, '0);
		send_cmd(FUNC_LOOKUP, MAX_VALUE_BYTES + 1'b1, '0, '0);     // lookup also checks the length
		send_cmd(FUNC_LOOKUP, MAX_VALUE_BYTES, '0, '0);
		send_cmd(FUNC_LOOKUP, '0, 16'd1, '0);
		send_cmd(FUNC_LOOKUP, '0, '1, '0);
		send_cmd(FUNC_EXPIRE, '0, '0, '1);                         // expiry still disabled
		drain_results();
		write_reg(CFG_TTL, 32'd1);
		write_reg(CFG_MAX_COUNT, 32'd64);
		src_gap_max = 5;
		sink_gap_max = 5;
		send_cmd(FUNC_EXPIRE, '0, '0, '1);                         // the newest segment always stays
		send_cmd(FUNC_APPEND, 25'd4096, '0, '0);
		send_cmd(FUNC_EXPIRE, '0, '0, 32'd10);                     // clock not past the stamp
		send_cmd(FUNC_LOOKUP, '0, '0, '0);
		drain_results();
	endtask

	// Near-maximal appends that open a run of segments, with a long receiver hold on the way.
	task automatic test_ring_fill();
		int unsigned     k;
		logic [ID_W-1:0] probe;
		write_reg(CFG_MAX_COUNT, 32'd0);
		write_reg(CFG_TTL, 32'd0);
		src_gap_max = 0;
		sink_gap_max = 0;
		k = 0;
		while (k < RING_FILL_WORDS) begin
			// long receiver hold: the block backs up and stalls its input
			if (k == 60)
				hold_req = 400;
			if (k == 120) begin
				src_gap_max = 5;
				sink_gap_max = 5;
			end
			wall_secs += $urandom_range(3, 1);
			case ($urandom_range(15))
				0: send_cmd(FUNC_EXPIRE, '0, '0, wall_secs);
				1, 2: begin
					probe = oldest_id - 1'b1 + ID_W'($urandom_range(seg_count + 1));
					send_cmd(FUNC_LOOKUP, LEN_W'($urandom_range(MAX_VALUE_BYTES)), probe, wall_secs);
				end
				default: send_cmd(FUNC_APPEND, MAX_VALUE_BYTES - LEN_W'($urandom_range(3)),
						ID_W'($urandom), wall_secs);
			endcase
			k++;
		end
		drain_results();
	endtask

	// Count limit lowered far below the live count: each open still evicts only one.
	task automatic test_double_limit();
		write_reg(CFG_MAX_COUNT, 32'd2);
		src_gap_max = 5;
		sink_gap_max = 0;
		repeat (20) begin
			wall_secs++;
			send_cmd(FUNC_APPEND, MAX_VALUE_BYTES, '0, wall_secs);
		end
		drain_results();
	endtask

	// One expire sweeps the ring down to its newest segment.
	task automatic test_bulk_expire();
		write_reg(CFG_TTL, 32'd1);
		src_gap_max = 0;
		sink_gap_max = 5;
		send_cmd(FUNC_EXPIRE, '0, '0, '1);
		send_cmd(FUNC_LOOKUP, '0, oldest_id, '0);
		send_cmd(FUNC_LOOKUP, '0, oldest_id - 1'b1, '0);
		send_cmd(FUNC_LOOKUP, '0, oldest_id + 1'b1, '0);
		drain_results();
	endtask

	// Mixed traffic in four register settings.
	task automatic test_random();
		int unsigned       k;
		int unsigned       sel;
		logic [TIME_W-1:0] now;
		logic [LEN_W-1:0]  len;
		logic [ID_W-1:0]   probe;
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin
					write_reg(CFG_MAX_COUNT, 32'd0);
					write_reg(CFG_TTL, $urandom_range(400, 20));
					src_gap_max = 5;
					sink_gap_max = 5;
				end
				1: begin
					write_reg(CFG_MAX_COUNT, $urandom_range(6, 1));
					write_reg(CFG_TTL, 32'd1);
					src_gap_max = 0;
					sink_gap_max = 5;
				end
				2: begin
					write_reg(CFG_MAX_COUNT, 32'd64);
					write_reg(CFG_TTL, '1);
					src_gap_max = 5;
					sink_gap_max = 0;
				end
				default: begin
					write_reg(CFG_MAX_COUNT, $urandom_range(64));
					write_reg(CFG_TTL, $urandom_range(1000, 1));
					src_gap_max = 5;
					sink_gap_max = 5;
				end
			endcase
			for (k = 0; k < RANDOM_WORDS / 4; k++) begin
				wall_secs += $urandom_range(40);
				// now and then a stray clock, often behind the stamps
				now = ($urandom_range(19) == 0) ? $urandom : wall_secs;
				sel = $urandom_range(99);
				if (sel < 55) begin
					case ($urandom_range(9))
						0: len = LEN_W'($urandom_range(64));
						1, 2: len = LEN_W'($urandom_range(MAX_VALUE_BYTES));
						3: len = LEN_W'($urandom_range(2 ** LEN_W - 1, MAX_VALUE_BYTES + 1));
						default: len = MAX_VALUE_BYTES - LEN_W'($urandom_range(64));
					endcase
					send_cmd(FUNC_APPEND, len, ID_W'($urandom), now);
				end else if (sel < 80) begin
					if ($urandom_range(9) == 0)
						len = LEN_W'($urandom_range(2 ** LEN_W - 1, MAX_VALUE_BYTES + 1));
					else
						len = LEN_W'($urandom_range(MAX_VALUE_BYTES));
					if ($urandom_range(9) < 3)
						probe = ID_W'($urandom);
					else
						probe = oldest_id - 1'b1 + ID_W'($urandom_range(seg_count + 1));
					send_cmd(FUNC_LOOKUP, len, probe, now);
				end else if (sel < 95) begin
					send_cmd(FUNC_EXPIRE, LEN_W'($urandom), ID_W'($urandom), now);
				end else begin
					send_cmd(FUNC_UNUSED, LEN_W'($urandom), ID_W'($urandom), $urandom);
				end
			end
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Result sink: random back-pressure, compare each word with the oldest expectation
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned wait_n;
		res_t        got;
		res_t        want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				wait_n = hold_req;
				hold_req = 0;
			end else begin
				wait_n = $urandom_range(sink_gap_max);
			end
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.status = m_tdata[R_STAT_LO +: STAT_W];
			got.result_segment = m_tdata[R_SEG_LO +: ID_W];
			got.result_offset = m_tdata[R_OFS_LO +: OFF_W];
			got.create_secs = m_tdata[R_SECS_LO +: TIME_W];
			got.removed_count = m_tdata[R_RM_LO +: CNT_W];
			got.evicted = m_tdata[R_EV_BIT];
			got.evicted_segment = m_tdata[R_EVSEG_LO +: ID_W];
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (got.status !== want.status || got.result_segment !== want.result_segment ||
						got.result_offset !== want.result_offset ||
						got.create_secs !== want.create_secs ||
						got.removed_count !== want.removed_count ||
						got.evicted !== want.evicted ||
						got.evicted_segment !== want.evicted_segment)
					note_failure($sformatf({"mismatch (expected/actual): status %0d/%0d ",
						"segment %0d/%0d offset %0d/%0d created %0d/%0d removed %0d/%0d ",
						"evicted %0d/%0d id %0d/%0d"},
						want.status, got.status, want.result_segment, got.result_segment,
						want.result_offset, got.result_offset, want.create_secs, got.create_secs,
						want.removed_count, got.removed_count, want.evicted, got.evicted,
						want.evicted_segment, got.evicted_segment));
			end
		end
	end

	// Watchdog: count cycles in which no handshake completes on any channel.
	int unsigned stall_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", stall_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ring_fill();
		test_double_limit();
		test_bulk_expire();
		test_random();
		// watch for stray words past the longest expiry walk
		repeat (DRAIN_TAIL) @(posedge clk);
		mismatch_count += expected_results.size();
		$display("summary: %0d words, %0d appends placed, %0d lookup hits, %0d segments opened",
			words_sent, appends_placed, lookups_found, segments_opened);
		$display("summary: %0d depth evictions, %0d count evictions, %0d expired, %0d errors",
			depth_evictions, count_evictions, segments_expired, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
design/lsra_pkg.sv
design/lsra_core.sv
design/log_segment_ring_allocator.sv
verif/tb_log_segment_ring_allocator.sv
